// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the encoder RTL
// Clocked on aclk, with checks switched off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rspe_pkg.sv =====
// ----------------------------------------------------------------------------
// rspe_pkg
// Constants, types and GF(256) arithmetic for the Reed-Solomon parity encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rspe_pkg;

    localparam int MAX_PARITY = 32;
    localparam int BYTE_W     = 8;
    localparam int CNT_W      = 6;
    localparam int IDX_W      = $clog2(MAX_PARITY);

    // x^8 + x^4 + x^3 + x^2 + 1
    localparam logic [BYTE_W:0]   FIELD_POLY  = 9'h11D;
    localparam logic [CNT_W-1:0]  COUNT_RESET = 6'd7;

    // Register map (index into the register list)
    localparam logic REG_PARITY_COUNT = 1'b0;

    typedef logic [MAX_PARITY:0][BYTE_W-1:0]   coef_arr_t;
    typedef logic [MAX_PARITY-1:0][BYTE_W-1:0] par_arr_t;

    // Control from the top level to the parity register
    typedef struct packed {
        logic clear;   // drop all parity, start a new message
        logic step;    // shift one data byte into the LFSR
        logic shift;   // move the parity out by one byte
    } lfsr_ctl_t;

    // Multiply by alpha
    function automatic logic [BYTE_W-1:0] gf_times_two(input logic [BYTE_W-1:0] a);
        gf_times_two = {a[BYTE_W-2:0], 1'b0} ^ (a[BYTE_W-1] ? FIELD_POLY[BYTE_W-1:0]
                                                           : {BYTE_W{1'b0}});
    endfunction

    // Full GF(256) product, shift-and-add over the 8 bits of b
    function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                                 input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] sh;
        acc = '0;
        sh  = a;
        for (int k = 0; k < BYTE_W; k++) begin
            if (b[k]) begin
                acc = acc ^ sh;
            end
            sh = gf_times_two(sh);
        end
        gf_mul = acc;
    endfunction

    // Clamp the register value into 1..MAX_PARITY
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
        if (c == '0) begin
            eff_count = CNT_W'(1);
        end else if (c > CNT_W'(MAX_PARITY)) begin
            eff_count = CNT_W'(MAX_PARITY);
        end else begin
            eff_count = c;
        end
    endfunction

endpackage

// ===== sv/rspe_gen.sv =====
// ----------------------------------------------------------------------------
// rspe_gen
// Derives the generator polynomial, one root (alpha^i) per clock cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rspe_gen (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [rspe_pkg::CNT_W-1:0]  count,
    output rspe_pkg::coef_arr_t         coefs,
    output logic                        busy
);

    rspe_pkg::coef_arr_t               coef_reg;
    rspe_pkg::coef_arr_t               coef_next;
    logic [rspe_pkg::BYTE_W-1:0]       root_reg;
    logic [rspe_pkg::CNT_W-1:0]        step_reg;
    logic                              busy_reg;

    // Multiply the polynomial by (x + root): all taps from the old values
    always_comb begin
        coef_next[0] = coef_reg[0];
        for (int j = 1; j <= rspe_pkg::MAX_PARITY; j++) begin
            coef_next[j] = coef_reg[j] ^ rspe_pkg::gf_mul(coef_reg[j-1], root_reg);
        end
    end

    // Restart on reset or a new count, then run count steps
    always_ff @(posedge aclk) begin
        if (!aresetn || start) begin
            // Leading coefficient 1, all others zero
            coef_reg    <= rspe_pkg::coef_arr_t'(1);
            root_reg    <= rspe_pkg::BYTE_W'(1);
            step_reg    <= '0;
            busy_reg    <= 1'b1;
        end else if (busy_reg) begin
            coef_reg <= coef_next;
            root_reg <= rspe_pkg::gf_times_two(root_reg);
            step_reg <= step_reg + 1'b1;
            if (step_reg == count - 1'b1) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign coefs = coef_reg;
    assign busy  = busy_reg;

endmodule

// ===== sv/rspe_lfsr.sv =====
// ----------------------------------------------------------------------------
// rspe_lfsr
// Parity register: takes one data byte per cycle while ctl.step is set, then shifts the parity out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rspe_lfsr (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  rspe_pkg::lfsr_ctl_t          ctl,
    input  logic [rspe_pkg::BYTE_W-1:0]  data_in,
    input  rspe_pkg::coef_arr_t          coefs,
    output logic [rspe_pkg::BYTE_W-1:0]  head
);

    rspe_pkg::par_arr_t           par_reg;
    rspe_pkg::par_arr_t           step_next;
    rspe_pkg::par_arr_t           shift_next;
    logic [rspe_pkg::BYTE_W-1:0]  factor;

    assign factor = data_in ^ par_reg[0];

    // Taps beyond the degree have zero coefficients, so one formula fits all
    always_comb begin
        for (int j = 0; j < rspe_pkg::MAX_PARITY; j++) begin
            if (j + 1 < rspe_pkg::MAX_PARITY) begin
                step_next[j]  = par_reg[j+1] ^ rspe_pkg::gf_mul(coefs[j+1], factor);
                shift_next[j] = par_reg[j+1];
            end else begin
                step_next[j]  = rspe_pkg::gf_mul(coefs[j+1], factor);
                shift_next[j] = '0;
            end
        end
    end

    // Shifting out all n bytes leaves the register zero for the next message
    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            par_reg <= '0;
        end else if (ctl.step) begin
            par_reg <= step_next;
        end else if (ctl.shift) begin
            par_reg <= shift_next;
        end
    end

    assign head = par_reg[0];

endmodule

// ===== sv/rs_parity_encoder_gf256.sv =====
// Reed-Solomon parity encoder over GF(256), field polynomial 0x11D.
// Input stream (s_*): one data byte per item in s_tdata, s_tlast on the final
// byte of a message. Output stream (m_*): every data byte comes out unchanged
// with m_tuser low; after the final byte the n parity bytes follow with
// m_tuser high, highest-order first, m_tlast on the last parity byte.
// An accepted byte appears on m_* in the cycle after it is taken. Throughput: one
// data byte per cycle while m_tready is high; after a message end the input stalls
// while the n parity bytes are sent from the single output register.
// APB register 0 (address 0): parity_count, 6 bits, 0 acts as 1, above 32
// acts as 32. A write clears the parity and rebuilds the generator.
// Reset: parity_count returns to 7 and the generator is rebuilt, one root per
// cycle, so s_tready stays low while it is rebuilt after reset or after a
// write. While m_tvalid is high and m_tready low, the output register holds
// and s_tready drops; nothing is lost.
// ----------------------------------------------------------------------------
// rs_parity_encoder_gf256
// Systematic Reed-Solomon encoder top level: APB register, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module rs_parity_encoder_gf256 (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tlast,    // last_byte
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic        m_tuser,    // [0] is_parity
    output logic        m_tlast     // last_out
);

    logic [rspe_pkg::CNT_W-1:0]   count_reg;
    logic [rspe_pkg::CNT_W-1:0]   count_eff;
    logic                         cfg_write;
    logic                         cfg_hit;

    rspe_pkg::coef_arr_t          coefs;
    logic                         gen_busy;
    rspe_pkg::lfsr_ctl_t          lfsr_ctl;
    logic [rspe_pkg::BYTE_W-1:0]  par_head;

    logic                         drain_reg;
    logic [rspe_pkg::IDX_W-1:0]   drain_cnt_reg;
    logic                         drain_final;

    logic                         out_valid_reg;
    logic [rspe_pkg::BYTE_W-1:0]  out_byte_reg;
    logic                         out_par_reg;
    logic                         out_last_reg;

    logic                         load_en;
    logic                         in_fire;
    logic                         drain_fire;

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_hit   = (paddr[2] == rspe_pkg::REG_PARITY_COUNT);
    assign cfg_write = psel && penable && pwrite && pready && cfg_hit;
    assign prdata    = cfg_hit ? {26'b0, count_reg} : 32'b0;
    assign count_eff = rspe_pkg::eff_count(count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= rspe_pkg::COUNT_RESET;
        end else if (cfg_write) begin
            count_reg <= pwdata[rspe_pkg::CNT_W-1:0];
        end
    end

    // Handshakes
    assign load_en    = !out_valid_reg || m_tready;
    assign s_tready   = load_en && !drain_reg && !gen_busy;
    assign in_fire    = s_tvalid && s_tready;
    assign drain_fire = drain_reg && load_en;
    assign drain_final = ({1'b0, drain_cnt_reg} == count_eff - 1'b1);

    rspe_gen u_gen (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cfg_write),
        .count   (count_eff),
        .coefs   (coefs),
        .busy    (gen_busy)
    );

    assign lfsr_ctl.clear = cfg_write;
    assign lfsr_ctl.step  = in_fire;
    assign lfsr_ctl.shift = drain_fire;

    rspe_lfsr u_lfsr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (lfsr_ctl),
        .data_in (s_tdata),
        .coefs   (coefs),
        .head    (par_head)
    );

    // Parity drain: start after the last data byte, stop after n bytes
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_write) begin
            drain_reg     <= 1'b0;
            drain_cnt_reg <= '0;
        end else if (in_fire && s_tlast) begin
            drain_reg     <= 1'b1;
            drain_cnt_reg <= '0;
        end else if (drain_fire) begin
            drain_cnt_reg <= drain_cnt_reg + 1'b1;
            if (drain_final) begin
                drain_reg <= 1'b0;
            end
        end
    end

    // Output register: load a data byte or a parity byte, hold while stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_en) begin
            out_valid_reg <= in_fire || drain_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            out_byte_reg <= s_tdata;
            out_par_reg  <= 1'b0;
            out_last_reg <= 1'b0;
        end else if (drain_fire) begin
            out_byte_reg <= par_head;
            out_par_reg  <= 1'b1;
            out_last_reg <= drain_final;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_par_reg;
    assign m_tlast  = out_last_reg;

    // Checks
    `ASSERT_IMPL(a_no_input_in_drain, drain_reg, !s_tready,
        "input accepted while parity bytes are being sent")
    `ASSERT_IMPL(a_no_input_in_derive, gen_busy, !s_tready,
        "input accepted while the generator is being derived")
    `ASSERT_IMPL(a_last_is_parity, m_tvalid && m_tlast, m_tuser,
        "end of message marked on a data byte")
    `ASSERT_NEXT(a_drain_after_last, in_fire && s_tlast && !cfg_write, drain_reg,
        "no parity drain after the last data byte")

endmodule

// ===== tb/tb_rs_parity_encoder_gf256.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rs_parity_encoder_gf256
// Self-checking bench for the GF(256) Reed-Solomon parity encoder. A local
// encoder mirror predicts every pass-through and parity byte, and a checker
// compares each output item with the oldest prediction. Tests cover the reset
// count, count extremes and clamping, a count write between message parts,
// an unmapped register write, output back-pressure, and random messages
// under random idle cycles on both streams.
// ----------------------------------------------------------------------------

module tb_rs_parity_encoder_gf256;

    localparam int CLK_PERIOD    = 8;
    localparam int GAP_MAX       = 14;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 150;
    localparam int PHASE_ITEMS   = 14;

    // Register addresses: index 0 holds parity_count, index 1 maps to nothing
    localparam logic [2:0] ADDR_PARITY_COUNT = {rspe_pkg::REG_PARITY_COUNT, 2'b00};
    localparam logic [2:0] ADDR_UNMAPPED     = {~rspe_pkg::REG_PARITY_COUNT, 2'b00};

    typedef struct packed {
        logic [rspe_pkg::BYTE_W-1:0] val;
        logic                        parity;
        logic                        tail;
    } enc_item_t;

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] data_byte
    logic        s_tlast;    // last_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;    // [7:0] out_byte
    logic        m_tuser;    // [0] is_parity
    logic        m_tlast;    // last_out

    // Encoder mirror state
    logic [rspe_pkg::CNT_W-1:0]  count_reg;
    logic [rspe_pkg::BYTE_W-1:0] gen_coef [0:rspe_pkg::MAX_PARITY];
    logic [rspe_pkg::BYTE_W-1:0] lfsr     [0:rspe_pkg::MAX_PARITY-1];
    enc_item_t                   enc_expect_q[$];

    int err_count;
    bit tx_idle;
    bit rx_idle;
    int rx_wait;
    int rx_hold_cycles;

    rs_parity_encoder_gf256 i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // GF(256) arithmetic and encoder mirror
    // ------------------------------------------------------------------------

    function automatic logic [rspe_pkg::BYTE_W-1:0] gf_x2(
            input logic [rspe_pkg::BYTE_W-1:0] a);
        return {a[rspe_pkg::BYTE_W-2:0], 1'b0} ^
               (a[rspe_pkg::BYTE_W-1] ? rspe_pkg::FIELD_POLY[rspe_pkg::BYTE_W-1:0] : 8'h00);
    endfunction

    function automatic logic [rspe_pkg::BYTE_W-1:0] gf_prod(
            input logic [rspe_pkg::BYTE_W-1:0] a,
            input logic [rspe_pkg::BYTE_W-1:0] b);
        logic [rspe_pkg::BYTE_W-1:0] acc;
        logic [rspe_pkg::BYTE_W-1:0] sh;
        acc = '0;
        sh  = a;
        for (int k = 0; k < rspe_pkg::BYTE_W; k++) begin
            if (b[k]) begin
                acc = acc ^ sh;
            end
            sh = gf_x2(sh);
        end
        return acc;
    endfunction

    // Zero acts as one, anything above the maximum acts as the maximum
    function automatic int active_count();
        int n;
        n = int'(count_reg);
        if (n < 1) begin
            n = 1;
        end else if (n > rspe_pkg::MAX_PARITY) begin
            n = rspe_pkg::MAX_PARITY;
        end
        return n;
    endfunction

    // Store the count, rebuild the generator, drop any partial parity
    task automatic load_parity_count(input logic [rspe_pkg::CNT_W-1:0] value);
        int n;
        logic [rspe_pkg::BYTE_W-1:0] root;
        count_reg = value;
        n = active_count();
        root = 8'h01;
        for (int i = 0; i <= rspe_pkg::MAX_PARITY; i++) begin
            gen_coef[i] = '0;
        end
        gen_coef[0] = 8'h01;
        for (int i = 0; i < n; i++) begin
            for (int j = i + 1; j > 0; j--) begin
                gen_coef[j] = gen_coef[j] ^ gf_prod(gen_coef[j-1], root);
            end
            root = gf_x2(root);
        end
        for (int i = 0; i < rspe_pkg::MAX_PARITY; i++) begin
            lfsr[i] = '0;
        end
    endtask

    // Shift one accepted byte through the parity register, queue its outputs
    task automatic encode_byte(input logic [rspe_pkg::BYTE_W-1:0] d, input logic is_last);
        int n;
        logic [rspe_pkg::BYTE_W-1:0] fb;
        enc_item_t it;
        n  = active_count();
        fb = d ^ lfsr[0];
        for (int j = 0; j + 1 < n; j++) begin
            lfsr[j] = lfsr[j+1] ^ gf_prod(gen_coef[j+1], fb);
        end
        lfsr[n-1] = gf_prod(gen_coef[n], fb);
        it.val    = d;
        it.parity = 1'b0;
        it.tail   = 1'b0;
        enc_expect_q.push_back(it);
        if (is_last) begin
            for (int j = 0; j < n; j++) begin
                it.val    = lfsr[j];
                it.parity = 1'b1;
                it.tail   = (j == n - 1);
                enc_expect_q.push_back(it);
            end
            for (int j = 0; j < rspe_pkg::MAX_PARITY; j++) begin
                lfsr[j] = '0;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: stall driver and checker
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        err_count++;
    endtask

    // Drive m_tready: long hold-off first, then the per-item stall
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (rx_hold_cycles > 0) begin
                m_tready <= 1'b0;
                rx_hold_cycles--;
            end else if (rx_wait > 0) begin
                m_tready <= 1'b0;
                rx_wait--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compare each output item with the oldest prediction
    always @(posedge aclk) begin
        enc_item_t exp_it;
        if (aresetn && m_tvalid && m_tready) begin
            if (enc_expect_q.size() == 0) begin
                report_mismatch($sformatf("unexpected item data=%02h user=%b last=%b",
                                          m_tdata, m_tuser, m_tlast));
            end else begin
                exp_it = enc_expect_q.pop_front();
                if (m_tdata !== exp_it.val) begin
                    report_mismatch($sformatf("out_byte got %02h want %02h",
                                              m_tdata, exp_it.val));
                end
                if (m_tuser !== exp_it.parity) begin
                    report_mismatch($sformatf("is_parity got %b want %b",
                                              m_tuser, exp_it.parity));
                end
                if (m_tlast !== exp_it.tail) begin
                    report_mismatch($sformatf("last_out got %b want %b",
                                              m_tlast, exp_it.tail));
                end
            end
            rx_wait = rx_idle ? $urandom_range(0, GAP_MAX) : 0;
        end
    end

    // ------------------------------------------------------------------------
    // Input side and register access
    // ------------------------------------------------------------------------

    // Offer one byte after an optional gap; valid stays high for the next one
    task automatic send_byte(input logic [rspe_pkg::BYTE_W-1:0] d, input logic is_last);
        int gap;
        gap = tx_idle ? $urandom_range(0, GAP_MAX) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= is_last;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        encode_byte(d, is_last);
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++) begin
            send_byte(8'($urandom_range(0, 255)), i == len - 1);
        end
    endtask

    // Stop offering and wait until every predicted item has come out
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (enc_expect_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == ADDR_PARITY_COUNT) begin
            load_parity_count(data[rspe_pkg::CNT_W-1:0]);
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Read parity_count back and compare with the stored value
    task automatic check_count_readback();
        logic [31:0] got;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_PARITY_COUNT;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        got = prdata;
        if (got !== {{(32-rspe_pkg::CNT_W){1'b0}}, count_reg}) begin
            report_mismatch($sformatf("parity_count read %08h want %0d", got, count_reg));
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write a count with random upper bits, which the register drops
    task automatic set_count(input logic [rspe_pkg::CNT_W-1:0] value);
        apb_write(ADDR_PARITY_COUNT, {(32-rspe_pkg::CNT_W)'($urandom()), value});
        check_count_readback();
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    task automatic test_reset_state();
        check_count_readback();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b1);
        drain();
    endtask

    // Smallest, largest, zero and above-maximum counts
    task automatic test_count_extremes();
        logic [rspe_pkg::CNT_W-1:0] counts [0:4];
        counts = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd33};
        foreach (counts[i]) begin
            set_count(counts[i]);
            send_byte(8'hA5, 1'b0);
            send_byte(8'h5A, 1'b1);
            drain();
        end
    endtask

    // A count write between message parts clears the partial parity
    task automatic test_write_mid_message();
        send_byte(8'h3C, 1'b0);
        send_byte(8'hC3, 1'b0);
        drain();
        set_count(6'd4);
        send_byte(8'h80, 1'b1);
        drain();
    endtask

    // A write to an unmapped index changes neither the count nor the parity
    task automatic test_unmapped_write();
        send_byte(8'h7F, 1'b0);
        drain();
        apb_write(ADDR_UNMAPPED, 32'hFFFF_FFFF);
        check_count_readback();
        send_byte(8'hFE, 1'b1);
        drain();
    endtask

    // Hold the output off while bytes keep coming, so the input stalls
    task automatic test_backpressure();
        set_count(6'd32);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        rx_hold_cycles = HOLD_CYCLES;
        send_message(20);
        send_message(3);
        drain();
    endtask

    // Pause the sender until every result is out, then resume
    task automatic test_sender_pause();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_message(5);
        drain();
        send_message(6);
        drain();
    endtask

    // Random messages over several counts, with and without idle cycles
    task automatic test_random_messages();
        int items;
        int len;
        logic [rspe_pkg::CNT_W-1:0] value;
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: value = 6'd32;
                1: value = 6'd1;
                3: value = 6'd63;
                5: value = 6'd0;
                default: value = 6'($urandom_range(0, 63));
            endcase
            set_count(value);
            tx_idle = (p % 2 == 0);
            rx_idle = (p % 3 != 1);
            items = 0;
            while (items < PHASE_ITEMS) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 12);
                send_message(len);
                items += len;
            end
            drain();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        aresetn        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        err_count      = 0;
        tx_idle        = 1'b1;
        rx_idle        = 1'b1;
        rx_wait        = 0;
        rx_hold_cycles = 0;
        load_parity_count(rspe_pkg::COUNT_RESET);

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_count_extremes();
        test_write_mid_message();
        test_unmapped_write();
        test_backpressure();
        test_sender_pause();
        test_random_messages();

        drain();
        if (err_count == 0) begin
            $display("rs_parity_encoder_gf256 verification clean");
        end else begin
            $display("rs_parity_encoder_gf256 verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("rs_parity_encoder_gf256 verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/rspe_pkg.sv
sv/rspe_gen.sv
sv/rspe_lfsr.sv
sv/rs_parity_encoder_gf256.sv
tb/tb_rs_parity_encoder_gf256.sv
